### hdl/mrk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrk_pkg
// Types, constants and helpers shared by the mixed-radix key codec.
// ----------------------------------------------------------------------------
package mrk_pkg;

	// fixed field widths
	localparam int OPCODE_W    = 2;
	localparam int KEY_W       = 24;
	localparam int PACKED_W    = 48;
	localparam int SEL_W       = 3;
	localparam int NEWIDX_W    = 6;
	localparam int STATUS_W    = 3;
	localparam int COUNT_W     = 4;
	localparam int RADICES_W   = 56;
	localparam int MASK_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 56;

	// arithmetic constants
	localparam int MAX_AXES_DEF = 8;
	localparam int INDEX_BITS   = 6;
	localparam int KEY_BITS     = 24;
	localparam int RADIX_BITS   = 7;
	localparam int SPACE_W      = KEY_BITS + 1;
	localparam int PROD_W       = SPACE_W + RADIX_BITS;
	localparam int DIVCNT_W     = $clog2(KEY_BITS);

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_ENCODE  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_DECODE  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_REPLACE = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_COMPILE = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_INDEX = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_KEY   = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_AXIS  = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_SPACE = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_RADICES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COMPILE_MASK = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SPACE,
		S_CHECK,
		S_DIV,
		S_ENC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [KEY_W-1:0]    key_in;
		logic [PACKED_W-1:0] packed_indices;
		logic [SEL_W-1:0]    axis_select;
		logic [NEWIDX_W-1:0] new_index;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    key_out;
		logic [PACKED_W-1:0] indices_out;
	} res_t;

	// radix of one axis, clamped to 2 .. 2^INDEX_BITS
	function automatic logic [RADIX_BITS-1:0] radix_at(
		input logic [RADICES_W-1:0] radices,
		input logic [SEL_W-1:0]     axis
	);
		logic [RADIX_BITS-1:0] r;
		r = radices[axis*RADIX_BITS +: RADIX_BITS];
		if (r < RADIX_BITS'(2))
			r = RADIX_BITS'(2);
		else if (r > RADIX_BITS'(1 << INDEX_BITS))
			r = RADIX_BITS'(1 << INDEX_BITS);
		return r;
	endfunction

endpackage

### hdl/mixed_radix_key_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixed_radix_key_codec
// Mixed-radix key encode, decode, digit replace and compilation key, built
// round one shared multiplier and a bit-serial remainder divider.
// ----------------------------------------------------------------------------
// Steps: every operation first forms the space product of the radices in use,
// then checks it; encode then accumulates the key, decode divides the key by
// each radix, and replace and compilation key divide and re-encode (the divider
// takes one key bit a cycle). Errors found before the divider go straight to done.
// One item at a time: busy stays high until the done cycle; done lasts one
// cycle and the receiver cannot stall. Reset clears config, sequencer and done_q.
module mixed_radix_key_codec #(
	parameter int MAX_AXES = mrk_pkg::MAX_AXES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [mrk_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mrk_pkg::CFG_DATA_W-1:0]    cfg_data,
	// command side
	input  logic                              start,
	input  mrk_pkg::req_t                     request,
	output logic                              busy,
	// result side
	output logic                              done,
	output mrk_pkg::res_t                     result
);

	localparam int CW = $clog2(MAX_AXES + 1);
	localparam int AW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
	localparam int IB = mrk_pkg::INDEX_BITS;
	localparam int RB = mrk_pkg::RADIX_BITS;
	localparam int KB = mrk_pkg::KEY_BITS;

	// configuration registers
	logic [mrk_pkg::COUNT_W-1:0]   axis_count_q;
	logic [mrk_pkg::RADICES_W-1:0] radices_q;
	logic [mrk_pkg::MASK_W-1:0]    compile_mask_q;

	// latched command
	logic [mrk_pkg::OPCODE_W-1:0]  op_q;
	logic [KB-1:0]                 key_q;
	logic [mrk_pkg::SEL_W-1:0]     sel_q;
	logic [IB-1:0]                 newidx_q;

	// working state
	mrk_pkg::state_t               state_q, state_d;
	logic [CW-1:0]                 cnt_q;
	logic [mrk_pkg::SPACE_W-1:0]   space_q;
	logic                          ovf_q;
	logic [KB-1:0]                 acc_q;
	logic                          bad_q;
	logic [mrk_pkg::STATUS_W-1:0]  stat_q;
	logic [KB-1:0]                 quo_q;
	logic [RB-1:0]                 rem_q;
	logic [mrk_pkg::DIVCNT_W-1:0]  bit_q;
	logic [IB-1:0]                 dig_q [MAX_AXES];

	// result register
	logic                          done_q;
	mrk_pkg::res_t                 res_q;

	// derived signals
	logic [CW-1:0]                 n_used;
	logic [CW-1:0]                 cnt_m1;
	logic [AW-1:0]                 cnt_ax;
	logic [AW-1:0]                 enc_ax;
	logic [AW-1:0]                 rad_ax;
	logic [RB-1:0]                 rad;
	logic [RB-1:0]                 sel_rad;
	logic [mrk_pkg::SPACE_W-1:0]   mul_a;
	logic [mrk_pkg::PROD_W-1:0]    mul_p;
	logic [IB-1:0]                 enc_dig;
	logic [RB:0]                   rem_sh;
	logic                          rem_ge;
	logic                          cnt_at_n;
	logic                          key_ge_space;
	logic                          sel_ge_n;
	logic                          div_last;
	logic [mrk_pkg::PACKED_W-1:0]  dig_packed;

	// axes in use, clamped to the build size
	assign n_used = (axis_count_q > mrk_pkg::COUNT_W'(MAX_AXES)) ? CW'(MAX_AXES)
		: CW'(axis_count_q);

	assign cnt_m1   = cnt_q - CW'(1);
	assign cnt_ax   = cnt_q[AW-1:0];
	assign enc_ax   = cnt_m1[AW-1:0];
	assign cnt_at_n = (cnt_q == n_used);
	assign div_last = (bit_q == mrk_pkg::DIVCNT_W'(KB - 1));

	// radix for the axis under work
	assign rad_ax  = (state_q == mrk_pkg::S_ENC) ? enc_ax : cnt_ax;
	assign rad     = mrk_pkg::radix_at(radices_q, mrk_pkg::SEL_W'(rad_ax));
	assign sel_rad = mrk_pkg::radix_at(radices_q, sel_q);

	// shared multiplier: space product, then Horner accumulation of the key
	assign mul_a = (state_q == mrk_pkg::S_SPACE) ? space_q : {1'b0, acc_q};
	assign mul_p = mul_a * mrk_pkg::PROD_W'(rad);

	// digit fed into the accumulator
	always_comb begin
		enc_dig = dig_q[enc_ax];
		if (op_q == mrk_pkg::OP_REPLACE && mrk_pkg::SEL_W'(enc_ax) == sel_q)
			enc_dig = newidx_q;
		else if (op_q == mrk_pkg::OP_COMPILE && !compile_mask_q[mrk_pkg::SEL_W'(enc_ax)])
			enc_dig = '0;
	end

	// remainder step of the divider
	assign rem_sh = {rem_q, quo_q[KB-1]};
	assign rem_ge = (rem_sh >= {1'b0, rad});

	// range checks
	assign key_ge_space = ({1'b0, key_q} >= space_q);
	assign sel_ge_n     = ({1'b0, sel_q} >= 4'(n_used));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_count_q   <= '0;
			radices_q      <= '0;
			compile_mask_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mrk_pkg::REG_AXIS_COUNT:   axis_count_q   <= cfg_data[mrk_pkg::COUNT_W-1:0];
				mrk_pkg::REG_AXIS_RADICES: radices_q      <= cfg_data[mrk_pkg::RADICES_W-1:0];
				mrk_pkg::REG_COMPILE_MASK: compile_mask_q <= cfg_data[mrk_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrk_pkg::S_IDLE:
				if (start) state_d = mrk_pkg::S_SPACE;
			mrk_pkg::S_SPACE:
				if (cnt_at_n) state_d = mrk_pkg::S_CHECK;
			mrk_pkg::S_CHECK: begin
				if (ovf_q)
					state_d = mrk_pkg::S_DONE;
				else if (op_q == mrk_pkg::OP_ENCODE)
					state_d = mrk_pkg::S_ENC;
				else if (op_q == mrk_pkg::OP_REPLACE
					&& (sel_ge_n || {1'b0, newidx_q} >= sel_rad || key_ge_space))
					state_d = mrk_pkg::S_DONE;
				else if (key_ge_space)
					state_d = mrk_pkg::S_DONE;
				else
					state_d = mrk_pkg::S_DIV;
			end
			mrk_pkg::S_DIV:
				if (cnt_at_n)
					state_d = (op_q == mrk_pkg::OP_DECODE) ? mrk_pkg::S_DONE : mrk_pkg::S_ENC;
			mrk_pkg::S_ENC:
				if (cnt_q == '0) state_d = mrk_pkg::S_DONE;
			mrk_pkg::S_DONE:
				state_d = mrk_pkg::S_IDLE;
			default:
				state_d = mrk_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy = (state_q != mrk_pkg::S_IDLE);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrk_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == mrk_pkg::S_DONE);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			mrk_pkg::S_IDLE: begin
				op_q     <= request.opcode;
				key_q    <= request.key_in[KB-1:0];
				sel_q    <= request.axis_select;
				newidx_q <= request.new_index;
				for (int a = 0; a < MAX_AXES; a++)
					dig_q[a] <= request.packed_indices[a*IB +: IB];
				cnt_q    <= '0;
				space_q  <= mrk_pkg::SPACE_W'(1);
				ovf_q    <= 1'b0;
				stat_q   <= mrk_pkg::STAT_OK;
			end
			mrk_pkg::S_SPACE: begin
				if (!cnt_at_n) begin
					if (!ovf_q) begin
						if (mul_p > mrk_pkg::PROD_W'(1 << KB))
							ovf_q <= 1'b1;
						else
							space_q <= mul_p[mrk_pkg::SPACE_W-1:0];
					end
					cnt_q <= cnt_q + CW'(1);
				end
			end
			mrk_pkg::S_CHECK: begin
				acc_q <= '0;
				bad_q <= 1'b0;
				quo_q <= key_q;
				rem_q <= '0;
				bit_q <= '0;
				if (ovf_q) begin
					stat_q <= mrk_pkg::STAT_SPACE;
				end else if (op_q == mrk_pkg::OP_ENCODE) begin
					cnt_q <= n_used;
				end else if (op_q == mrk_pkg::OP_REPLACE && sel_ge_n) begin
					stat_q <= mrk_pkg::STAT_AXIS;
				end else if (op_q == mrk_pkg::OP_REPLACE && {1'b0, newidx_q} >= sel_rad) begin
					stat_q <= mrk_pkg::STAT_INDEX;
				end else if (key_ge_space) begin
					stat_q <= mrk_pkg::STAT_KEY;
				end else begin
					cnt_q <= '0;
				end
			end
			mrk_pkg::S_DIV: begin
				if (cnt_at_n) begin
					cnt_q <= n_used;
				end else begin
					// one quotient bit a cycle
					quo_q <= {quo_q[KB-2:0], rem_ge};
					if (div_last) begin
						dig_q[cnt_ax] <= rem_ge ? IB'(rem_sh - {1'b0, rad}) : IB'(rem_sh);
						rem_q         <= '0;
						bit_q         <= '0;
						cnt_q         <= cnt_q + CW'(1);
					end else begin
						rem_q <= rem_ge ? RB'(rem_sh - {1'b0, rad}) : RB'(rem_sh);
						bit_q <= bit_q + mrk_pkg::DIVCNT_W'(1);
					end
				end
			end
			mrk_pkg::S_ENC: begin
				if (cnt_q == '0) begin
					if (bad_q) stat_q <= mrk_pkg::STAT_INDEX;
				end else begin
					// key = key * radix + digit, top axis first
					acc_q <= mul_p[KB-1:0] + KB'(enc_dig);
					if (op_q == mrk_pkg::OP_ENCODE && {1'b0, enc_dig} >= rad)
						bad_q <= 1'b1;
					cnt_q <= cnt_m1;
				end
			end
			mrk_pkg::S_DONE: begin
				res_q.status      <= stat_q;
				res_q.key_out     <= (stat_q == mrk_pkg::STAT_OK && op_q != mrk_pkg::OP_DECODE)
					? mrk_pkg::KEY_W'(acc_q) : '0;
				res_q.indices_out <= (stat_q == mrk_pkg::STAT_OK && op_q == mrk_pkg::OP_DECODE)
					? dig_packed : '0;
			end
			default: ;
		endcase
	end

	// decoded digits, axes not in use read as zero
	always_comb begin
		dig_packed = '0;
		for (int a = 0; a < MAX_AXES; a++)
			if (CW'(a) < n_used)
				dig_packed[a*IB +: IB] = dig_q[a];
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
